[src/plcm_pkg.sv]
// Shared constants, types and helpers of the piecewise-linear color map.
`default_nettype none
package plcm_pkg;

  localparam int unsigned MaxStopsDef  = 7;
  localparam int unsigned ValueBitsDef = 16;
  localparam int unsigned CfgDataW     = 40;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CountW       = 3;
  localparam int unsigned ChanW        = 8;
  localparam int unsigned NumChan      = 3;
  localparam int unsigned QuotBits     = 8;
  localparam int unsigned PosLsb       = 24;
  localparam int unsigned SideW        = NumChan * ChanW + NumChan;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegStopCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStop0     = 3'd1;

  localparam logic [CountW-1:0]   CountMin   = 3'd2;
  localparam logic [CfgDataW-1:0] Stop1Reset = 40'h00FFFFFFFF;

  typedef struct packed {
    logic adv;
    logic valid;
  } pipe_ctrl_t;

  // Pick one color channel of a packed stop: 0 red, 1 green, 2 blue.
  function automatic logic [ChanW-1:0] stop_chan(input logic [CfgDataW-1:0] s,
                                                 input int unsigned c);
    stop_chan = s[ChanW*(NumChan-1-c) +: ChanW];
  endfunction

endpackage
`default_nettype wire

[src/plcm_if.sv]
// Channel interfaces: sample input, color output and register write.
`default_nettype none
interface plcm_in_if #(parameter int unsigned VALUE_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface plcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface plcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [39:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[src/plcm_div.sv]
// Pipelined restoring divider: one quotient bit per stage for three channels.
`default_nettype none
module plcm_div #(
  parameter int unsigned VALUE_BITS = plcm_pkg::ValueBitsDef
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  plcm_pkg::pipe_ctrl_t                              ctrl_i,
  input  logic [plcm_pkg::NumChan-1:0][VALUE_BITS+plcm_pkg::ChanW-1:0] num_i,
  input  logic [VALUE_BITS-1:0]                             den_i,
  input  logic [plcm_pkg::SideW-1:0]                        side_i,
  output logic                                              valid_o,
  output logic [plcm_pkg::NumChan-1:0][plcm_pkg::QuotBits-1:0] quot_o,
  output logic [plcm_pkg::NumChan-1:0]                      rem_nz_o,
  output logic [plcm_pkg::SideW-1:0]                        side_o
);
  import plcm_pkg::*;

  localparam int unsigned NW = VALUE_BITS + ChanW;

  logic                                   valid_q [QuotBits];
  logic [NumChan-1:0][NW-1:0]             rem_q   [QuotBits];
  logic [NumChan-1:0][QuotBits-1:0]       quot_q  [QuotBits];
  logic [VALUE_BITS-1:0]                  den_q   [QuotBits];
  logic [SideW-1:0]                       side_q  [QuotBits];

  for (genvar j = 0; j < QuotBits; j++) begin : g_stage
    logic                             p_valid;
    logic [NumChan-1:0][NW-1:0]       p_rem;
    logic [NumChan-1:0][QuotBits-1:0] p_quot;
    logic [VALUE_BITS-1:0]            p_den;
    logic [SideW-1:0]                 p_side;
    logic [NumChan-1:0][NW-1:0]       rem_d;
    logic [NumChan-1:0][QuotBits-1:0] quot_d;
    logic [NW-1:0]                    trial;

    if (j == 0) begin : g_first
      assign p_valid = ctrl_i.valid;
      assign p_rem   = num_i;
      assign p_quot  = '0;
      assign p_den   = den_i;
      assign p_side  = side_i;
    end else begin : g_next
      assign p_valid = valid_q[j-1];
      assign p_rem   = rem_q[j-1];
      assign p_quot  = quot_q[j-1];
      assign p_den   = den_q[j-1];
      assign p_side  = side_q[j-1];
    end

    // Try the shifted divisor against each channel's remainder
    assign trial = NW'(p_den) << (QuotBits - 1 - j);
    always_comb begin
      rem_d  = p_rem;
      quot_d = p_quot;
      for (int c = 0; c < NumChan; c++) begin
        if (p_rem[c] >= trial) begin
          rem_d[c]                      = p_rem[c] - trial;
          quot_d[c][QuotBits - 1 - j]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (ctrl_i.adv) begin
        valid_q[j] <= p_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.adv) begin
        rem_q[j]  <= rem_d;
        quot_q[j] <= quot_d;
        den_q[j]  <= p_den;
        side_q[j] <= p_side;
      end
    end
  end

  assign valid_o = valid_q[QuotBits-1];
  assign quot_o  = quot_q[QuotBits-1];
  assign side_o  = side_q[QuotBits-1];
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      rem_nz_o[c] = (rem_q[QuotBits-1][c] != '0);
    end
  end

endmodule
`default_nettype wire

[src/piecewise_linear_color_map.sv]
// Top level of the piecewise-linear color map: stop registers and pipeline.
// Throughput: one sample per clock; the pipeline is 12 register stages
// (select, subtract, multiply, 8 divider bit stages, output) and stalls as
// one whole when the output item is not taken.
// Reset: stop_count 2, stop_1 at position 255 white, other stops zero,
// pipeline empty; no clearing pass is needed.
`default_nettype none
module piecewise_linear_color_map #(
  parameter int unsigned MAX_STOPS  = plcm_pkg::MaxStopsDef,
  parameter int unsigned VALUE_BITS = plcm_pkg::ValueBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  plcm_cfg_if.sink          cfg_i,
  plcm_in_if.sink           sample_i,
  plcm_out_if.source        color_o
);
  import plcm_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_STOPS);
  localparam int unsigned NW   = VALUE_BITS + ChanW;
  localparam int unsigned ColW = NumChan * ChanW;

  // ---------------- configuration registers ----------------
  logic [CountW-1:0]   count_q;
  logic [CfgDataW-1:0] stop_q [MAX_STOPS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountMin;
      for (int k = 0; k < MAX_STOPS; k++) begin
        stop_q[k] <= (k == 1) ? Stop1Reset : '0;
      end
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegStopCount) begin
        count_q <= cfg_i.data[CountW-1:0];
      end
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (int'(cfg_i.index) == int'(RegStop0) + k) begin
          stop_q[k] <= cfg_i.data;
        end
      end
    end
  end

  // Clamp the stop count and take the last index in use
  logic [IdxW-1:0] last;
  always_comb begin
    if (count_q < CountMin) begin
      last = IdxW'(1);
    end else if (int'(count_q) > MAX_STOPS) begin
      last = IdxW'(MAX_STOPS - 1);
    end else begin
      last = IdxW'(count_q - 3'd1);
    end
  end

  // Unpack stop positions
  logic signed [VALUE_BITS-1:0] pos [MAX_STOPS];
  always_comb begin
    for (int k = 0; k < MAX_STOPS; k++) begin
      pos[k] = signed'(VALUE_BITS'({{PosLsb{1'b0}}, stop_q[k]} >> PosLsb));
    end
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_valid_q;
  assign adv            = !out_valid_q || color_o.ready;
  assign sample_i.ready = adv;

  // ---------------- stage 1: bracket search ----------------
  logic signed [VALUE_BITS-1:0] v;
  logic [IdxW-1:0]              sel;
  logic                         clamp;
  assign v = signed'(sample_i.sample_value);

  always_comb begin
    sel   = last;
    clamp = 1'b0;
    if (v <= pos[0]) begin
      clamp = 1'b1;
      sel   = '0;
    end else if (v >= pos[last]) begin
      clamp = 1'b1;
    end else begin
      // scan downward so the lowest matching stop wins
      for (int k = MAX_STOPS - 1; k >= 1; k--) begin
        if ((k < int'(last)) && (pos[k] > v)) begin
          sel = IdxW'(k);
        end
      end
    end
  end

  logic                         s1_valid_q, s1_clamp_q;
  logic signed [VALUE_BITS-1:0] s1_v_q, s1_ph_q, s1_pl_q;
  logic [ColW-1:0]              s1_hi_q, s1_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_clamp_q <= clamp;
      s1_v_q     <= v;
      s1_ph_q    <= pos[sel];
      s1_pl_q    <= clamp ? pos[sel] : pos[sel - IdxW'(1)];
      s1_hi_q    <= stop_q[sel][ColW-1:0];
      s1_lo_q    <= clamp ? stop_q[sel][ColW-1:0] : stop_q[sel - IdxW'(1)][ColW-1:0];
    end
  end

  // ---------------- stage 2: span, distance, color deltas ----------------
  logic signed [VALUE_BITS:0]  den_w, dist_w;
  logic [VALUE_BITS-1:0]       den_d, dist_d;
  logic [NumChan-1:0][ChanW-1:0] ch_d, mag_d;
  logic [NumChan-1:0]          neg_d;

  assign den_w  = {s1_ph_q[VALUE_BITS-1], s1_ph_q} - {s1_pl_q[VALUE_BITS-1], s1_pl_q};
  assign dist_w = {s1_ph_q[VALUE_BITS-1], s1_ph_q} - {s1_v_q[VALUE_BITS-1], s1_v_q};
  assign den_d  = s1_clamp_q ? VALUE_BITS'(1) : den_w[VALUE_BITS-1:0];
  assign dist_d = s1_clamp_q ? '0 : dist_w[VALUE_BITS-1:0];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      ch_d[c]  = stop_chan(CfgDataW'(s1_hi_q), c);
      neg_d[c] = stop_chan(CfgDataW'(s1_lo_q), c) < ch_d[c];
      mag_d[c] = neg_d[c] ? ch_d[c] - stop_chan(CfgDataW'(s1_lo_q), c)
                          : stop_chan(CfgDataW'(s1_lo_q), c) - ch_d[c];
    end
  end

  logic                          s2_valid_q;
  logic [VALUE_BITS-1:0]         s2_den_q, s2_dist_q;
  logic [NumChan-1:0][ChanW-1:0] s2_ch_q, s2_mag_q;
  logic [NumChan-1:0]            s2_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_den_q  <= den_d;
      s2_dist_q <= dist_d;
      s2_ch_q   <= ch_d;
      s2_mag_q  <= mag_d;
      s2_neg_q  <= neg_d;
    end
  end

  // ---------------- stage 3: scale deltas by distance ----------------
  logic                          s3_valid_q;
  logic [NumChan-1:0][NW-1:0]    s3_num_q;
  logic [VALUE_BITS-1:0]         s3_den_q;
  logic [SideW-1:0]              s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NumChan; c++) begin
        s3_num_q[c] <= NW'(s2_dist_q) * NW'(s2_mag_q[c]);
      end
      s3_den_q  <= s2_den_q;
      s3_side_q <= {s2_ch_q, s2_neg_q};
    end
  end

  // ---------------- divider stages ----------------
  pipe_ctrl_t                          div_ctrl;
  logic                                div_valid;
  logic [NumChan-1:0][QuotBits-1:0]    div_quot;
  logic [NumChan-1:0]                  div_rem_nz;
  logic [SideW-1:0]                    div_side;

  assign div_ctrl.adv   = adv;
  assign div_ctrl.valid = s3_valid_q;

  plcm_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .num_i    (s3_num_q),
    .den_i    (s3_den_q),
    .side_i   (s3_side_q),
    .valid_o  (div_valid),
    .quot_o   (div_quot),
    .rem_nz_o (div_rem_nz),
    .side_o   (div_side)
  );

  // ---------------- output stage: apply floored offset ----------------
  logic [NumChan-1:0][ChanW-1:0] fin_ch;
  logic [NumChan-1:0]            fin_neg;
  logic [NumChan-1:0][ChanW-1:0] col_d;
  logic [NumChan-1:0][ChanW-1:0] col_q;

  assign {fin_ch, fin_neg} = div_side;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      // a negative slope floors away from the upper color
      col_d[c] = fin_neg[c] ? fin_ch[c] - div_quot[c] - ChanW'(div_rem_nz[c])
                            : fin_ch[c] + div_quot[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col_q <= col_d;
    end
  end

  assign color_o.valid = out_valid_q;
  assign color_o.red   = col_q[0];
  assign color_o.green = col_q[1];
  assign color_o.blue  = col_q[2];

  // ---------------- assertions ----------------
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !color_o.valid |-> sample_i.ready)
    else $error("input not ready while output stage is empty");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (color_o.valid && !color_o.ready) |=> (color_o.valid && $stable(col_q)))
    else $error("output item changed during stall");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q) |=> s2_valid_q)
    else $error("item lost between select and subtract stages");

endmodule
`default_nettype wire

[dv/piecewise_linear_color_map_checker.sv]
// Checker for the color map: predicts each color and compares it with the output.
`timescale 1ns / 1ps
module piecewise_linear_color_map_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  plcm_cfg_if    cfg,
  plcm_in_if     smp,
  plcm_out_if    col,
  output int     fail_count_o,
  output int     pending_o
);
  import plcm_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  localparam int unsigned ExpDepth = 64;

  logic [2:0]  stop_count_q;
  logic [39:0] stop_q [7];
  color_t      exp_mem [ExpDepth];
  logic [5:0]  wr_ptr_q;
  logic [5:0]  rd_ptr_q;
  logic [5:0]  fill;

  function automatic int stop_position(int k);
    return int'($signed(stop_q[k][39:24]));
  endfunction

  // Compute the floored, interpolated color for one sample.
  function automatic color_t map_sample(logic [15:0] raw);
    int     v, n, last, i, ph, pl, den, offset, ch, cl, num, q;
    color_t res;
    logic [7:0] chan [3];
    v = int'($signed(raw));
    n = stop_count_q;
    if (n < 2) n = 2;
    if (n > 7) n = 7;
    last = n - 1;
    if (v <= stop_position(0)) return color_t'(stop_q[0][23:0]);
    if (v >= stop_position(last)) return color_t'(stop_q[last][23:0]);
    for (i = 1; i < last; i++) if (stop_position(i) > v) break;
    ph     = stop_position(i);
    pl     = stop_position(i - 1);
    den    = ph - pl;
    offset = ph - v;
    for (int c = 0; c < 3; c++) begin
      ch  = stop_q[i][16 - 8*c +: 8];
      cl  = stop_q[i - 1][16 - 8*c +: 8];
      num = offset * (cl - ch);
      q   = num / den;
      if ((num % den) != 0 && num < 0) q--;
      chan[c] = 8'(ch + q);
    end
    res.red = chan[0];
    res.green = chan[1];
    res.blue = chan[2];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count_o++;
  endtask

  assign fill      = wr_ptr_q - rd_ptr_q;
  assign pending_o = int'(fill);

  initial fail_count_o = 0;

  // Track registers, queue predictions and compare outputs.
  always @(posedge clk_i or negedge rst_ni) begin
    color_t want;
    if (!rst_ni) begin
      stop_count_q <= CountMin;
      for (int k = 0; k < 7; k++) stop_q[k] <= (k == 1) ? Stop1Reset : '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (smp.valid && smp.ready) begin
        exp_mem[wr_ptr_q] <= map_sample(smp.sample_value);
        wr_ptr_q <= wr_ptr_q + 6'd1;
      end
      if (col.valid && col.ready) begin
        if (wr_ptr_q == rd_ptr_q) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = exp_mem[rd_ptr_q];
          rd_ptr_q <= rd_ptr_q + 6'd1;
          if (col.red != want.red) report_mismatch("red", col.red, want.red);
          if (col.green != want.green) report_mismatch("green", col.green, want.green);
          if (col.blue != want.blue) report_mismatch("blue", col.blue, want.blue);
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == RegStopCount) stop_count_q <= cfg.data[2:0];
        else stop_q[cfg.index - RegStop0] <= cfg.data;
      end
    end
  end
endmodule

[dv/piecewise_linear_color_map_tb.sv]
// Testbench top: drives register writes, samples and output stalls.
`timescale 1ns / 1ps
module piecewise_linear_color_map_tb;
  import plcm_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   src_idle;
  int   snk_idle;

  plcm_cfg_if    cfg ();
  plcm_in_if     smp ();
  plcm_out_if    col ();

  piecewise_linear_color_map i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (smp),
    .color_o  (col)
  );

  piecewise_linear_color_map_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg          (cfg),
    .smp          (smp),
    .col          (col),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stall the output at the current rate.
  always @(posedge clk_i) col.ready <= ($urandom_range(99) >= snk_idle);

  task automatic write_reg(logic [2:0] idx, logic [39:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold valid between back-to-back items; drop it only while idling.
  task automatic send_sample(logic [15:0] value);
    while ($urandom_range(99) < src_idle) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid        <= 1'b1;
    smp.sample_value <= value;
    do @(posedge clk_i); while (!smp.ready);
  endtask

  // Hold until the pipeline has drained, then let it settle.
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  function automatic logic [39:0] pack_stop(int pos, logic [23:0] rgb);
    return {16'(pos), rgb};
  endfunction

  // Set the stop count and load all seven stops at ascending positions, some tight, some wide.
  task automatic load_table(int count, bit wide);
    int pos;
    write_reg(RegStopCount, 40'(count));
    pos = wide ? -32768 : $urandom_range(200) - 100;
    for (int k = 0; k < 7; k++) begin
      write_reg(RegStop0 + 3'(k), pack_stop(pos, 24'($urandom)));
      if (wide) pos += (k == 0) ? 32767 : 0;
      pos += wide ? 1 : $urandom_range(40, 1);
      if (pos > 32767) pos = 32767;
    end
  endtask

  task automatic random_samples(int n, bit wide);
    for (int j = 0; j < n; j++)
      send_sample(wide ? 16'($urandom) : 16'($urandom_range(500) - 150));
  endtask

  initial begin
    int counts [6] = '{2, 7, 0, 1, 4, 5};
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    smp.valid = 1'b0; smp.sample_value = '0;
    col.ready = 1'b0;
    src_idle = 26; snk_idle = 59;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset table, field extremes, clamps on both ends.
    send_sample(16'h8000); send_sample(16'h7FFF); send_sample(16'h0000);
    send_sample(16'd255); send_sample(16'd128); send_sample(16'hFFFF);
    drain();
    // Full range table with extreme colors, count seven.
    write_reg(RegStopCount, 40'd7);
    write_reg(RegStop0, pack_stop(-32768, 24'h000000));
    write_reg(RegStop0 + 3'd1, pack_stop(-1, 24'hFFFFFF));
    write_reg(RegStop0 + 3'd2, pack_stop(0, 24'h00FF00));
    write_reg(RegStop0 + 3'd3, pack_stop(100, 24'hFF00FF));
    write_reg(RegStop0 + 3'd4, pack_stop(50, 24'h123456));
    write_reg(RegStop0 + 3'd5, pack_stop(1000, 24'hAA55AA));
    write_reg(RegStop0 + 3'd6, pack_stop(32767, 24'h55AA55));
    send_sample(16'h8000); send_sample(16'h8001); send_sample(16'hFFFF);
    send_sample(16'd0); send_sample(16'd75); send_sample(16'd99);
    send_sample(16'd500); send_sample(16'h7FFE); send_sample(16'h7FFF);
    drain();
    // Stop counts below two are clamped in the block.
    write_reg(RegStopCount, 40'd0);
    send_sample(16'hC000); send_sample(16'd7);
    drain();
    write_reg(RegStopCount, 40'd1);
    send_sample(16'hC000);
    drain();

    // Random phases across idling patterns and table settings.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin src_idle = 59; snk_idle = 26; end
      if (ph == 8) begin src_idle = 0; snk_idle = 0; end
      load_table(counts[ph % 6], ph % 3 == 2);
      random_samples(78, ph % 3 == 2);
      drain();
    end

    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
